@@ hw/rtl/erdc_pkg.sv @@
package erdc_pkg;

	localparam int START_W = 52;
	localparam int COUNT_W = 21;
	localparam int WORD_W = 64;
	localparam int BYTE_W = 63;
	localparam int LEN_W = 52;
	localparam int GB_W = 6;
	localparam int BPG_W = 32;
	localparam int BL_W = 5;
	localparam int CFG_DATA_W = 63;
	localparam int CFG_INDEX_W = 2;
	localparam int HI_START_BITS = 9;
	localparam int SPLIT_W = 26;
	localparam int PP_LO_W = SPLIT_W + BPG_W;
	localparam int PP_HI_W = WORD_W - SPLIT_W;

	localparam logic [BYTE_W-1:0] BYTE_MAX = {BYTE_W{1'b1}};

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_GROUP_BLOCK_BITS = 2'd0,
		CFG_BLOCKS_PER_GROUP = 2'd1,
		CFG_BLOCK_SIZE_LOG   = 2'd2,
		CFG_VOLUME_BYTES     = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [GB_W-1:0]   group_block_bits;
		logic [BPG_W-1:0]  blocks_per_group;
		logic [BL_W-1:0]   block_size_log;
		logic [BYTE_W-1:0] volume_bytes;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic              keep;
		logic              last;
		logic [BYTE_W-1:0] offset;
		logic [LEN_W-1:0]  length;
	} extent_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] offset;
		logic [BYTE_W-1:0] length;
		logic              present;
		logic              eol;
	} result_t;

endpackage

@@ hw/rtl/erdc_offset.sv @@
module erdc_offset import erdc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                accept,
	input  logic [WORD_W-1:0]   word0,
	input  logic [WORD_W-1:0]   word1,
	input  logic                last,
	input  cfg_t                cfg,
	output extent_item_t        item
);

	logic [START_W-1:0] start;
	logic [WORD_W-1:0]  inside_mask;

	logic               v_s1;
	logic [START_W-1:0] group_s1;
	logic [START_W-1:0] inside_s1;
	logic [COUNT_W-1:0] count_s1;
	logic               last_s1;

	logic               v_s2;
	logic [PP_LO_W-1:0] pp_lo_s2;
	logic [PP_HI_W-1:0] pp_hi_s2;
	logic [START_W-1:0] inside_s2;
	logic [COUNT_W-1:0] count_s2;
	logic               last_s2;

	logic [WORD_W-1:0]  base;
	logic [WORD_W-1:0]  off64;
	logic [LEN_W-1:0]   len;

	logic               v_s3;
	logic               keep_s3;
	logic               last_s3;
	logic [BYTE_W-1:0]  off_s3;
	logic [LEN_W-1:0]   len_s3;

	assign start = {word0[HI_START_BITS-1:0], word1[WORD_W-1:COUNT_W]};
	assign inside_mask = ~({WORD_W{1'b1}} << cfg.group_block_bits);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			group_s1 <= start >> cfg.group_block_bits;
			inside_s1 <= start & inside_mask[START_W-1:0];
			count_s1 <= word1[COUNT_W-1:0];
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pp_lo_s2 <= PP_LO_W'(group_s1[SPLIT_W-1:0]) * PP_LO_W'(cfg.blocks_per_group);
			pp_hi_s2 <= PP_HI_W'(group_s1[START_W-1:SPLIT_W]) * PP_HI_W'(cfg.blocks_per_group);
			inside_s2 <= inside_s1;
			count_s2 <= count_s1;
			last_s2 <= last_s1;
		end
	end

	assign base = WORD_W'(pp_lo_s2) + {pp_hi_s2, {SPLIT_W{1'b0}}} + WORD_W'(inside_s2);
	assign off64 = base << cfg.block_size_log;
	assign len = LEN_W'(count_s2) << cfg.block_size_log;

	always_ff @(posedge clk) begin
		if (adv) begin
			off_s3 <= off64[BYTE_W-1:0];
			len_s3 <= len;
			keep_s3 <= (count_s2 != '0) && !off64[WORD_W-1]
				&& (off64[BYTE_W-1:0] < cfg.volume_bytes);
			last_s3 <= last_s2;
		end
	end

	assign item = '{valid: v_s3, keep: keep_s3, last: last_s3,
		offset: off_s3, length: len_s3};

endmodule

@@ hw/rtl/erdc_outq.sv @@
module erdc_outq import erdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  push_n,
	input  result_t     ent0,
	input  result_t     ent1,
	input  logic        pop,
	output result_t     head,
	output logic        nonempty,
	output logic        room
);

	localparam int DEPTH = 4;
	localparam int PTR_W = 2;

	result_t          mem [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   count_q;
	logic [PTR_W-1:0] wr_next;

	assign wr_next = wr_q + PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem[wr_q] <= ent0;
		end
		if (push_n == 2'd2) begin
			mem[wr_next] <= ent1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + PTR_W'(push_n);
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			count_q <= count_q + (PTR_W+1)'(push_n) - (PTR_W+1)'(pop);
		end
	end

	assign head = mem[rd_q];
	assign nonempty = (count_q != '0);
	assign room = (count_q <= (PTR_W+1)'(DEPTH - 2));

endmodule

@@ hw/rtl/extent_record_decode_coalesce_top.sv @@
// Decodes packed 128-bit extent records into byte extents on the volume and merges
// contiguous ones. A record is taken every cycle while the input is not stalled, and
// passes through the registers s1, s2 and s3 before it is merged; results leave
// through a four-entry queue, and the input is stalled while that queue holds more
// than two results, so the sustained rate is one record per cycle unless the output
// side stalls or many records each emit two results. The volume size resets to zero,
// so every extent is dropped until that register is written.
module extent_record_decode_coalesce_top import erdc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [WORD_W-1:0]      record_word0,
	input  logic [WORD_W-1:0]      record_word1,
	input  logic                   last_record,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [BYTE_W-1:0]      extent_offset,
	output logic [BYTE_W-1:0]      extent_length,
	output logic                   extent_present,
	output logic                   end_of_list
);

	cfg_t              cfg_q;
	extent_item_t      item;
	logic              adv;
	logic              fire;
	logic              room;

	logic              pend_v_q;
	logic [BYTE_W-1:0] pend_off_q;
	logic [BYTE_W-1:0] pend_len_q;

	logic              cont;
	logic [WORD_W-1:0] sum;
	logic [BYTE_W-1:0] merged;
	logic              nv;
	logic [BYTE_W-1:0] no;
	logic [BYTE_W-1:0] nl;
	logic [1:0]        npush;
	result_t           e0;
	result_t           e1;
	result_t           e_end;
	result_t           head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.group_block_bits <= GB_W'(16);
			cfg_q.blocks_per_group <= BPG_W'(65536);
			cfg_q.block_size_log <= BL_W'(12);
			cfg_q.volume_bytes <= '0;
		end else if (cfg_write) begin
			case (cfg_index_t'(cfg_index))
				CFG_GROUP_BLOCK_BITS: cfg_q.group_block_bits <= cfg_data[GB_W-1:0];
				CFG_BLOCKS_PER_GROUP: cfg_q.blocks_per_group <= cfg_data[BPG_W-1:0];
				CFG_BLOCK_SIZE_LOG:   cfg_q.block_size_log <= cfg_data[BL_W-1:0];
				CFG_VOLUME_BYTES:     cfg_q.volume_bytes <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv = room;
	assign in_stall = !adv;

	erdc_offset u_offset (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.accept (in_valid && adv),
		.word0  (record_word0),
		.word1  (record_word1),
		.last   (last_record),
		.cfg    (cfg_q),
		.item   (item)
	);

	assign fire = adv && item.valid;

	assign cont = pend_v_q
		&& (({1'b0, pend_off_q} + {1'b0, pend_len_q}) == {1'b0, item.offset});
	assign sum = {1'b0, pend_len_q} + WORD_W'(item.length);
	assign merged = sum[WORD_W-1] ? BYTE_MAX : sum[BYTE_W-1:0];

	always_comb begin
		nv = pend_v_q;
		no = pend_off_q;
		nl = pend_len_q;
		npush = 2'd0;
		e0 = '0;
		e1 = '0;
		e_end = '0;
		if (item.keep) begin
			if (cont) begin
				nl = merged;
			end else begin
				if (pend_v_q) begin
					e0 = '{offset: pend_off_q, length: pend_len_q, present: 1'b1, eol: 1'b0};
					npush = 2'd1;
				end
				nv = 1'b1;
				no = item.offset;
				nl = BYTE_W'(item.length);
			end
		end
		if (item.last) begin
			if (nv) begin
				e_end = '{offset: no, length: nl, present: 1'b1, eol: 1'b1};
			end else begin
				e_end = '{offset: '0, length: '0, present: 1'b0, eol: 1'b1};
			end
			if (npush == 2'd0) begin
				e0 = e_end;
			end else begin
				e1 = e_end;
			end
			npush = npush + 2'd1;
			nv = 1'b0;
			no = '0;
			nl = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			pend_off_q <= '0;
			pend_len_q <= '0;
		end else if (fire) begin
			pend_v_q <= nv;
			pend_off_q <= no;
			pend_len_q <= nl;
		end
	end

	erdc_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (fire ? npush : 2'd0),
		.ent0     (e0),
		.ent1     (e1),
		.pop      (out_valid && !out_stall),
		.head     (head),
		.nonempty (out_valid),
		.room     (room)
	);

	assign extent_offset = head.offset;
	assign extent_length = head.length;
	assign extent_present = head.present;
	assign end_of_list = head.eol;

`ifndef ASSERT_OFF
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.last) |=> !pend_v_q)
		else $error("pending extent survived the end of the list");

	a_pend_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (pend_len_q != '0))
		else $error("pending extent has zero length");

	a_empty_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !extent_present) |->
		(end_of_list && extent_offset == '0 && extent_length == '0))
		else $error("empty result is not a clean end mark");
`endif

endmodule

@@ tb/sv/tb.sv @@
module tb;
	import erdc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 12;
	localparam int SEGMENTS = 5;
	localparam int SEGMENT_RECORDS = 130;
	localparam logic [20:0] FULL_COUNT = 21'h1FFFFF;

	typedef enum logic {ROW_RECORD, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		cfg_index_t        idx;
		logic [BYTE_W-1:0] value;
		logic [WORD_W-1:0] w0;
		logic [WORD_W-1:0] w1;
		logic              last;
		bit                typed;
		result_t           want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [WORD_W-1:0] record_word0 = '0;
	logic [WORD_W-1:0] record_word1 = '0;
	logic last_record = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [BYTE_W-1:0] extent_offset;
	logic [BYTE_W-1:0] extent_length;
	logic extent_present;
	logic end_of_list;

	logic [GB_W-1:0] cfg_gb = 6'd16;
	logic [BPG_W-1:0] cfg_bpg = 32'd65536;
	logic [BL_W-1:0] cfg_bl = 5'd12;
	logic [BYTE_W-1:0] cfg_vol = '0;

	logic pend_valid = 1'b0;
	logic [BYTE_W-1:0] pend_off = '0;
	logic [BYTE_W-1:0] pend_len = '0;

	result_t new_extents [2];
	result_t extents_due [$];
	stim_row_t rows [$];

	int snd_idle = 0;
	int rcv_idle = 0;
	int errors = 0;
	int cycles = 0;
	int n_records = 0;
	int n_checked = 0;
	int n_writes = 0;

	extent_record_decode_coalesce_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.record_word0(record_word0),
		.record_word1(record_word1),
		.last_record(last_record),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.extent_offset(extent_offset),
		.extent_length(extent_length),
		.extent_present(extent_present),
		.end_of_list(end_of_list)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("extent_record_decode_coalesce_top: mismatch");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rcv_idle);
	end

	function automatic void add_due(input result_t r);
		extents_due.insert(extents_due.size(), r);
	endfunction

	function automatic void add_row(input stim_row_t r);
		rows.insert(rows.size(), r);
	endfunction

	function automatic result_t mk_res(input logic [BYTE_W-1:0] o, l, input logic p, e);
		result_t r;
		r.offset = o;
		r.length = l;
		r.present = p;
		r.eol = e;
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] hi_word(input logic [START_W-1:0] s);
		return {55'd0, s[51:43]};
	endfunction

	function automatic logic [WORD_W-1:0] lo_word(input logic [START_W-1:0] s,
			input logic [COUNT_W-1:0] c);
		return {s[42:0], c};
	endfunction

	function automatic stim_row_t rec(input logic [WORD_W-1:0] w0, w1, input logic last);
		stim_row_t r;
		r.kind = ROW_RECORD;
		r.idx = CFG_GROUP_BLOCK_BITS;
		r.value = '0;
		r.w0 = w0;
		r.w1 = w1;
		r.last = last;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic stim_row_t rec_typed(input logic [WORD_W-1:0] w0, w1,
			input logic last, input result_t want);
		stim_row_t r;
		r = rec(w0, w1, last);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic stim_row_t reg_row(input cfg_index_t idx, input logic [BYTE_W-1:0] v);
		stim_row_t r;
		r = rec('0, '0, 1'b0);
		r.kind = ROW_WRITE;
		r.idx = idx;
		r.value = v;
		return r;
	endfunction

	function automatic int coalesce_record(input logic [WORD_W-1:0] w0, w1, input logic last);
		logic [63:0] start;
		logic [63:0] cnt;
		logic [63:0] grp;
		logic [63:0] ins;
		logic [63:0] off;
		logic [63:0] len;
		logic [63:0] sum;
		int n;
		n = 0;
		start = {12'd0, w0[8:0], w1[63:21]};
		cnt = {43'd0, w1[20:0]};
		if (cnt != 64'd0) begin
			grp = start >> cfg_gb;
			ins = start & ((64'd1 << cfg_gb) - 64'd1);
			off = (grp * {32'd0, cfg_bpg} + ins) << cfg_bl;
			len = cnt << cfg_bl;
			if (!off[63] && off[62:0] < cfg_vol) begin
				if (pend_valid && ({1'b0, pend_off} + {1'b0, pend_len}) == off) begin
					sum = {1'b0, pend_len} + len;
					pend_len = sum[63] ? BYTE_MAX : sum[62:0];
				end else begin
					if (pend_valid) begin
						new_extents[n] = mk_res(pend_off, pend_len, 1'b1, 1'b0);
						n++;
					end
					pend_valid = 1'b1;
					pend_off = off[62:0];
					pend_len = len[62:0];
				end
			end
		end
		if (last) begin
			new_extents[n] = pend_valid ? mk_res(pend_off, pend_len, 1'b1, 1'b1)
				: mk_res('0, '0, 1'b0, 1'b1);
			n++;
			pend_valid = 1'b0;
			pend_off = '0;
			pend_len = '0;
		end
		return n;
	endfunction

	task automatic send_record(input logic [WORD_W-1:0] w0, w1, input logic last,
			input bit typed, input result_t want);
		int n;
		while ($urandom_range(0, 99) < snd_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		record_word0 <= w0;
		record_word1 <= w1;
		last_record <= last;
		do @(posedge clk); while (in_stall);
		n = coalesce_record(w0, w1, last);
		if (typed)
			add_due(want);
		else
			for (int i = 0; i < n; i++)
				add_due(new_extents[i]);
		n_records++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (extents_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] v);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			CFG_GROUP_BLOCK_BITS: cfg_gb = v[GB_W-1:0];
			CFG_BLOCKS_PER_GROUP: cfg_bpg = v[BPG_W-1:0];
			CFG_BLOCK_SIZE_LOG: cfg_bl = v[BL_W-1:0];
			CFG_VOLUME_BYTES: cfg_vol = v;
			default: ;
		endcase
		n_writes++;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	task automatic quiesce();
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic random_config();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: write_reg(CFG_GROUP_BLOCK_BITS, 63'd0);
			1: write_reg(CFG_GROUP_BLOCK_BITS, 63'd1);
			2: write_reg(CFG_GROUP_BLOCK_BITS, 63'd16);
			3: write_reg(CFG_GROUP_BLOCK_BITS, 63'd32);
			4: write_reg(CFG_GROUP_BLOCK_BITS, 63'd63);
			default: write_reg(CFG_GROUP_BLOCK_BITS, 63'($urandom_range(0, 63)));
		endcase
		case ($urandom_range(0, 5))
			0: write_reg(CFG_BLOCKS_PER_GROUP, 63'd1);
			1: write_reg(CFG_BLOCKS_PER_GROUP, 63'hFFFF_FFFF);
			2: write_reg(CFG_BLOCKS_PER_GROUP, 63'd65536);
			3: write_reg(CFG_BLOCKS_PER_GROUP, 63'd0);
			default: write_reg(CFG_BLOCKS_PER_GROUP, {r[62:32], 32'($urandom)});
		endcase
		case ($urandom_range(0, 6))
			0: write_reg(CFG_BLOCK_SIZE_LOG, 63'd9);
			1: write_reg(CFG_BLOCK_SIZE_LOG, 63'd16);
			2: write_reg(CFG_BLOCK_SIZE_LOG, 63'd12);
			3: write_reg(CFG_BLOCK_SIZE_LOG, 63'd0);
			4: write_reg(CFG_BLOCK_SIZE_LOG, 63'd31);
			default: write_reg(CFG_BLOCK_SIZE_LOG, 63'($urandom_range(0, 31)));
		endcase
		case ($urandom_range(0, 9))
			0: write_reg(CFG_VOLUME_BYTES, 63'd0);
			1, 2: write_reg(CFG_VOLUME_BYTES, r[62:0]);
			3, 4: write_reg(CFG_VOLUME_BYTES, {23'd0, r[39:0]});
			default: write_reg(CFG_VOLUME_BYTES, BYTE_MAX);
		endcase
	endtask

	task automatic random_records(input int count);
		logic [63:0] r;
		logic [63:0] m;
		logic [START_W-1:0] s;
		logic [START_W-1:0] prev_s;
		logic [COUNT_W-1:0] c;
		logic [COUNT_W-1:0] prev_c;
		logic [WORD_W-1:0] w0;
		logic [WORD_W-1:0] w1;
		int sel;
		prev_s = '0;
		prev_c = '0;
		for (int i = 0; i < count; i++) begin
			r = {$urandom, $urandom};
			m = {$urandom, $urandom};
			c = 21'(m) & ((21'd1 << $urandom_range(1, 21)) - 21'd1);
			if ($urandom_range(0, 7) == 0)
				c = FULL_COUNT;
			sel = $urandom_range(0, 99);
			if (sel < 55)
				s = prev_s + 52'(prev_c);
			else
				s = r[51:0] & ((52'd1 << $urandom_range(0, 52)) - 52'd1);
			if (sel >= 87)
				c = '0;
			w0 = hi_word(s);
			w1 = lo_word(s, c);
			if (sel >= 75 && sel < 87) begin
				w0 = r;
				w1 = m;
			end
			prev_s = {w0[8:0], w1[63:21]};
			prev_c = w1[20:0];
			if ($urandom_range(0, 99) == 0)
				wait_drained();
			send_record(w0, w1, ($urandom_range(0, 9) == 0), 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (extents_due.size() == 0) begin
				$error("unexpected extent: offset %h length %h", extent_offset, extent_length);
				errors++;
			end else begin
				want = extents_due.pop_front();
				n_checked++;
				if (extent_offset !== want.offset) begin
					$error("extent_offset: expected %h, got %h", want.offset, extent_offset);
					errors++;
				end
				if (extent_length !== want.length) begin
					$error("extent_length: expected %h, got %h", want.length, extent_length);
					errors++;
				end
				if (extent_present !== want.present) begin
					$error("extent_present: expected %b, got %b", want.present, extent_present);
					errors++;
				end
				if (end_of_list !== want.eol) begin
					$error("end_of_list: expected %b, got %b", want.eol, end_of_list);
					errors++;
				end
			end
		end
	end

	initial begin
		int snd_pct [3];
		int rcv_pct [3];
		snd_pct = '{33, 84, 0};
		rcv_pct = '{84, 33, 0};

		add_row(rec_typed(hi_word(0), lo_word(0, 1), 1'b1, mk_res(0, 0, 0, 1)));
		add_row(rec_typed('1, '1, 1'b1, mk_res(0, 0, 0, 1)));
		add_row(rec(hi_word(0), lo_word(0, 0), 1'b0));
		add_row(rec_typed(hi_word(7), lo_word(7, 0), 1'b1, mk_res(0, 0, 0, 1)));
		add_row(reg_row(CFG_VOLUME_BYTES, BYTE_MAX));
		add_row(rec_typed(hi_word(0), lo_word(0, 1), 1'b1, mk_res(0, 4096, 1, 1)));
		add_row(rec(hi_word(1), lo_word(1, 1), 1'b0));
		add_row(rec(hi_word(2), lo_word(2, 3), 1'b0));
		add_row(rec(hi_word(10), lo_word(10, 1), 1'b1));
		add_row(rec_typed(hi_word('1), lo_word('1, 1), 1'b1, mk_res(0, 0, 0, 1)));
		add_row(rec(hi_word(0), lo_word(0, FULL_COUNT), 1'b0));
		add_row(rec(hi_word(52'h1FFFFF), lo_word(52'h1FFFFF, FULL_COUNT), 1'b1));
		add_row(rec(64'hFFFF_FFFF_FFFF_FE00, lo_word(5, 2), 1'b0));
		add_row(rec(hi_word(0), lo_word(0, 0), 1'b1));
		add_row(reg_row(CFG_VOLUME_BYTES, 63'h10_0000));
		add_row(rec(hi_word(52'hFF), lo_word(52'hFF, 1), 1'b0));
		add_row(rec(hi_word(52'h100), lo_word(52'h100, 1), 1'b0));
		add_row(rec_typed(hi_word(52'h101), lo_word(52'h101, 5), 1'b1,
			mk_res(63'hFF000, 4096, 1, 1)));
		add_row(reg_row(CFG_GROUP_BLOCK_BITS, 63'd0));
		add_row(reg_row(CFG_BLOCKS_PER_GROUP, 63'd1));
		add_row(reg_row(CFG_BLOCK_SIZE_LOG, 63'd9));
		add_row(reg_row(CFG_VOLUME_BYTES, BYTE_MAX));
		add_row(rec(hi_word(52'h12345), lo_word(52'h12345, 21'h10), 1'b0));
		add_row(rec(hi_word(52'h12355), lo_word(52'h12355, 21'h3), 1'b1));
		add_row(reg_row(CFG_GROUP_BLOCK_BITS, 63'd63));
		add_row(reg_row(CFG_BLOCKS_PER_GROUP, 63'hFFFF_FFFF));
		add_row(reg_row(CFG_BLOCK_SIZE_LOG, 63'd31));
		add_row(rec(hi_word(1), lo_word(1, FULL_COUNT), 1'b0));
		add_row(rec(hi_word(52'h200000), lo_word(52'h200000, 1), 1'b1));
		add_row(reg_row(CFG_GROUP_BLOCK_BITS, 63'd32));
		add_row(reg_row(CFG_BLOCK_SIZE_LOG, 63'd16));
		add_row(rec(hi_word(52'hABCDE_1234_5678), lo_word(52'hABCDE_1234_5678, 1), 1'b1));
		add_row(reg_row(CFG_GROUP_BLOCK_BITS, 63'd1));
		add_row(reg_row(CFG_BLOCKS_PER_GROUP, 63'd3));
		add_row(reg_row(CFG_BLOCK_SIZE_LOG, 63'd0));
		add_row(rec(hi_word(52'hFFF), lo_word(52'hFFF, 7), 1'b1));

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_WRITE) begin
				quiesce();
				write_reg(rows[i].idx, rows[i].value);
			end else begin
				send_record(rows[i].w0, rows[i].w1, rows[i].last, rows[i].typed, rows[i].want);
			end
		end

		for (int ph = 0; ph < 3; ph++) begin
			snd_idle = snd_pct[ph];
			rcv_idle = rcv_pct[ph];
			for (int seg = 0; seg < SEGMENTS; seg++) begin
				quiesce();
				random_config();
				random_records(SEGMENT_RECORDS);
			end
		end

		wait_drained();
		repeat (4 * SETTLE_CYCLES) @(negedge clk);

		$display("Sent %0d extent records and checked %0d extents over %0d register writes,",
			n_records, n_checked, n_writes);
		$display("across three stall patterns with drops, merges and empty list ends.");
		if (errors == 0)
			$display("extent_record_decode_coalesce_top: match");
		else
			$display("extent_record_decode_coalesce_top: mismatch");
		$finish;
	end

endmodule
